[src/c8ic_pkg.sv]
package c8ic_pkg;

	// Sizes
	localparam int PC_W        = 12;
	localparam int MEM_BYTES   = 4096;
	localparam int ADDR_W      = $clog2(MEM_BYTES);
	localparam int STACK_DEPTH = 16;
	localparam int SP_W        = $clog2(STACK_DEPTH);
	localparam int SCREEN_W    = 64;
	localparam int SCREEN_H    = 32;
	localparam int COL_W       = $clog2(SCREEN_W);
	localparam int ROW_W       = $clog2(SCREEN_H);
	localparam int CNT_W       = ROW_W + 1;

	localparam logic [PC_W-1:0] RESET_PC  = 12'h200;
	localparam logic [15:0]     FONT_BASE = 16'h0050;
	localparam logic [15:0]     ADDR_MASK = 16'h0FFF;

	// Opcode groups (top nibble)
	localparam logic [3:0] G_SYS  = 4'h0;
	localparam logic [3:0] G_JP   = 4'h1;
	localparam logic [3:0] G_CALL = 4'h2;
	localparam logic [3:0] G_SE   = 4'h3;
	localparam logic [3:0] G_SNE  = 4'h4;
	localparam logic [3:0] G_SER  = 4'h5;
	localparam logic [3:0] G_LD   = 4'h6;
	localparam logic [3:0] G_ADD  = 4'h7;
	localparam logic [3:0] G_ALU  = 4'h8;
	localparam logic [3:0] G_SNER = 4'h9;
	localparam logic [3:0] G_LDI  = 4'hA;
	localparam logic [3:0] G_JPV  = 4'hB;
	localparam logic [3:0] G_RND  = 4'hC;
	localparam logic [3:0] G_DRW  = 4'hD;
	localparam logic [3:0] G_KEY  = 4'hE;
	localparam logic [3:0] G_MISC = 4'hF;

	localparam logic [15:0] OP_CLS = 16'h00E0;
	localparam logic [15:0] OP_RET = 16'h00EE;

	// 8XYN sub-codes
	localparam logic [3:0] N_MOV  = 4'h0;
	localparam logic [3:0] N_OR   = 4'h1;
	localparam logic [3:0] N_AND  = 4'h2;
	localparam logic [3:0] N_XOR  = 4'h3;
	localparam logic [3:0] N_ADD  = 4'h4;
	localparam logic [3:0] N_SUB  = 4'h5;
	localparam logic [3:0] N_SHR  = 4'h6;
	localparam logic [3:0] N_SUBN = 4'h7;
	localparam logic [3:0] N_SHL  = 4'hE;

	// EXNN / FXNN sub-codes
	localparam logic [7:0] EX_SKP       = 8'h9E;
	localparam logic [7:0] EX_SKNP      = 8'hA1;
	localparam logic [7:0] FX_GET_DELAY = 8'h07;
	localparam logic [7:0] FX_WAIT_KEY  = 8'h0A;
	localparam logic [7:0] FX_SET_DELAY = 8'h15;
	localparam logic [7:0] FX_SET_SOUND = 8'h18;
	localparam logic [7:0] FX_ADD_INDEX = 8'h1E;
	localparam logic [7:0] FX_FONT      = 8'h29;
	localparam logic [7:0] FX_BCD       = 8'h33;
	localparam logic [7:0] FX_STORE     = 8'h55;
	localparam logic [7:0] FX_LOAD      = 8'h65;

	// Config register indexes
	localparam logic CFG_SUPER_QUIRKS   = 1'b0;
	localparam logic CFG_INDEX_OVERFLOW = 1'b1;

	typedef enum logic [1:0] {
		MODE_EXEC = 2'd0,
		MODE_TICK = 2'd1,
		MODE_LOAD = 2'd2,
		MODE_ROW  = 2'd3
	} mode_t;

	typedef struct packed {
		mode_t       mode;
		logic [15:0] key_mask;
		logic [7:0]  random_byte;
		logic [11:0] load_address;
		logic [7:0]  load_byte;
		logic [4:0]  row_select;
	} item_t;

	typedef struct packed {
		logic [11:0] program_counter;
		logic        screen_changed;
		logic        sound_active;
		logic        waiting_for_key;
		logic [63:0] row_pixels;
	} result_t;

	typedef struct packed {
		logic super_quirks;
		logic index_overflow_flag;
	} cfg_t;

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] addr;
		logic [7:0]        wdata;
	} mem_req_t;

	typedef enum logic [3:0] {
		ALU_PASS_B,
		ALU_OR,
		ALU_AND,
		ALU_XOR,
		ALU_ADD,
		ALU_SUB,
		ALU_SUBN,
		ALU_SHR,
		ALU_SHL
	} alu_op_t;

	typedef struct packed {
		logic [7:0] res;
		logic       flag;
	} alu_out_t;

	typedef enum logic [4:0] {
		S_CLEAR,
		S_IDLE,
		S_FETCH0,
		S_FETCH1,
		S_FETCH2,
		S_RDX,
		S_RDY,
		S_EXEC,
		S_WRF,
		S_CLS,
		S_DRAW_RD,
		S_DRAW_WR,
		S_DRAW_VF,
		S_BCD,
		S_STORE,
		S_LOAD_RD,
		S_LOAD_WR,
		S_IDXADD,
		S_ROW,
		S_DONE
	} state_t;

endpackage

[src/c8ic_ram.sv]
module c8ic_ram (
	input  logic               clk,
	input  c8ic_pkg::mem_req_t req,
	output logic [7:0]         rdata
);
	import c8ic_pkg::*;

	logic [7:0] mem_q [MEM_BYTES];
	logic [7:0] rd_q;

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem_q[req.addr] <= req.wdata;
		end
		rd_q <= mem_q[req.addr];
	end

	assign rdata = rd_q;

endmodule

[src/c8ic_alu.sv]
module c8ic_alu (
	input  c8ic_pkg::alu_op_t  op,
	input  logic [7:0]         a,
	input  logic [7:0]         b,
	output c8ic_pkg::alu_out_t y
);
	import c8ic_pkg::*;

	logic [8:0] sum;

	assign sum = {1'b0, a} + {1'b0, b};

	always_comb begin
		y.res  = b;
		y.flag = 1'b0;
		case (op)
			ALU_PASS_B: y.res = b;
			ALU_OR:     y.res = a | b;
			ALU_AND:    y.res = a & b;
			ALU_XOR:    y.res = a ^ b;
			ALU_ADD: begin
				y.res  = sum[7:0];
				y.flag = sum[8];
			end
			ALU_SUB: begin
				y.res  = a - b;
				y.flag = (a >= b);
			end
			ALU_SUBN: begin
				y.res  = b - a;
				y.flag = (b >= a);
			end
			ALU_SHR: begin
				y.res  = {1'b0, a[7:1]};
				y.flag = a[0];
			end
			ALU_SHL: begin
				y.res  = {a[6:0], 1'b0};
				y.flag = a[7];
			end
			default: y.res = b;
		endcase
	end

endmodule

[src/c8ic_seq.sv]
module c8ic_seq (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	input  c8ic_pkg::item_t    item,
	output logic               item_stall,
	input  c8ic_pkg::cfg_t     cfg,
	input  logic               out_free,
	output logic               done,
	output c8ic_pkg::result_t  res,
	output c8ic_pkg::mem_req_t mem_req,
	input  logic [7:0]         mem_rdata
);
	import c8ic_pkg::*;

	// architectural state
	logic [7:0]      rf_q [16];
	logic [PC_W-1:0] stack_q [STACK_DEPTH];
	logic [SP_W-1:0] sp_q;
	logic [PC_W-1:0] pc_q;
	logic [15:0]     idx_q;
	logic [7:0]      dt_q;
	logic [7:0]      st_q;
	logic [63:0]     pix_q [SCREEN_H];

	// working registers
	state_t            state_q, state_d;
	item_t             item_q;
	logic [15:0]       op_q;
	logic [7:0]        vx_q, vy_q;
	logic              flag_q, coll_q, changed_q, waiting_q;
	logic [63:0]       row_q, pix_rd_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [ADDR_W-1:0] clr_q;

	// combinational
	logic              accept;
	logic [3:0]        opg, rx, ry, rn;
	logic [7:0]        nn;
	logic [PC_W-1:0]   nnn;
	logic [3:0]        ra;
	logic [7:0]        rf_rd;
	logic              rf_we;
	logic [3:0]        rf_wa;
	logic [7:0]        rf_wd;
	logic [ROW_W-1:0]  pix_ra, pix_wa;
	logic              pix_we;
	logic [63:0]       pix_wd, sprite;
	alu_op_t           alu_op;
	logic [7:0]        alu_a, alu_b;
	alu_out_t          alu_y;
	logic              alu_zero, key_held, key_any, draw_go;
	logic [3:0]        key_low;
	logic [15:0]       idx_sum;
	logic [ADDR_W-1:0] idx_mem;
	logic [CNT_W-1:0]  draw_row, cnt_m1;
	logic [SP_W-1:0]   sp_inc, sp_dec;

	function automatic logic [7:0] bcd_digit(input logic [7:0] v, input logic [1:0] sel);
		logic [15:0] p_h, p_t;
		logic [7:0]  h, t, q2;
		p_h = 16'(v) * 16'd41;
		h   = {4'b0, p_h[15:12]};
		p_t = 16'(v) * 16'd205;
		t   = {3'b0, p_t[15:11]};
		q2  = 8'((16'(t) * 16'd13) >> 7);
		case (sel)
			2'd0:    bcd_digit = h;
			2'd1:    bcd_digit = t - 8'(q2 * 8'd10);
			default: bcd_digit = v - 8'(t * 8'd10);
		endcase
	endfunction

	function automatic logic [3:0] lowest_key(input logic [15:0] k);
		logic [3:0] r;
		r = 4'd0;
		for (int i = 15; i >= 0; i--) begin
			if (k[i]) r = 4'(i);
		end
		return r;
	endfunction

	c8ic_alu u_alu (
		.op (alu_op),
		.a  (alu_a),
		.b  (alu_b),
		.y  (alu_y)
	);

	assign opg = op_q[15:12];
	assign rx  = op_q[11:8];
	assign ry  = op_q[7:4];
	assign rn  = op_q[3:0];
	assign nn  = op_q[7:0];
	assign nnn = op_q[11:0];

	assign accept     = (state_q == S_IDLE) && item_valid;
	assign item_stall = (state_q != S_IDLE);
	assign rf_rd      = rf_q[ra];
	assign alu_zero   = (alu_y.res == 8'd0);
	assign key_held   = (vx_q[7:4] == 4'd0) && item_q.key_mask[vx_q[3:0]];
	assign key_any    = |item_q.key_mask;
	assign key_low    = lowest_key(item_q.key_mask);
	assign idx_sum    = idx_q + {8'b0, vx_q};
	assign idx_mem    = idx_q[ADDR_W-1:0] + ADDR_W'(cnt_q);
	assign draw_row   = {1'b0, vy_q[ROW_W-1:0]} + cnt_q;
	assign draw_go    = (cnt_q < CNT_W'(rn)) && (draw_row < CNT_W'(SCREEN_H));
	assign cnt_m1     = cnt_q - CNT_W'(1);
	assign sprite     = {mem_rdata, 56'b0} >> vx_q[COL_W-1:0];
	assign sp_inc     = (sp_q == SP_W'(STACK_DEPTH - 1)) ? '0 : sp_q + SP_W'(1);
	assign sp_dec     = (sp_q == '0) ? SP_W'(STACK_DEPTH - 1) : sp_q - SP_W'(1);

	assign done                = (state_q == S_DONE) && out_free;
	assign res.program_counter = pc_q;
	assign res.screen_changed  = changed_q;
	assign res.sound_active    = (st_q != 8'd0);
	assign res.waiting_for_key = waiting_q;
	assign res.row_pixels      = row_q;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_CLEAR: if (clr_q == '1) state_d = S_IDLE;
			S_IDLE: begin
				if (accept) begin
					case (item.mode)
						MODE_EXEC: state_d = S_FETCH0;
						MODE_ROW:  state_d = S_ROW;
						default:   state_d = S_DONE;
					endcase
				end
			end
			S_FETCH0: state_d = S_FETCH1;
			S_FETCH1: state_d = S_FETCH2;
			S_FETCH2: state_d = S_RDX;
			S_RDX:    state_d = S_RDY;
			S_RDY:    state_d = S_EXEC;
			S_EXEC: begin
				state_d = S_DONE;
				case (opg)
					G_SYS: if (op_q == OP_CLS) state_d = S_CLS;
					G_ALU: begin
						if (rn == N_ADD || rn == N_SUB || rn == N_SHR ||
						    rn == N_SUBN || rn == N_SHL)
							state_d = S_WRF;
					end
					G_DRW: state_d = S_DRAW_RD;
					G_MISC: begin
						case (nn)
							FX_ADD_INDEX: if (cfg.index_overflow_flag) state_d = S_WRF;
							FX_BCD:       state_d = S_BCD;
							FX_STORE:     state_d = S_STORE;
							FX_LOAD:      state_d = S_LOAD_RD;
							default:      state_d = S_DONE;
						endcase
					end
					default: state_d = S_DONE;
				endcase
			end
			S_WRF:     state_d = S_DONE;
			S_CLS:     if (cnt_q == CNT_W'(SCREEN_H)) state_d = S_DONE;
			S_DRAW_RD: state_d = draw_go ? S_DRAW_WR : S_DRAW_VF;
			S_DRAW_WR: state_d = S_DRAW_RD;
			S_DRAW_VF: state_d = S_DONE;
			S_BCD:     if (cnt_q == CNT_W'(2)) state_d = S_DONE;
			S_STORE:   if (cnt_q[3:0] == rx) state_d = S_IDXADD;
			S_LOAD_RD: state_d = S_LOAD_WR;
			S_LOAD_WR: state_d = (cnt_q[3:0] == rx) ? S_IDXADD : S_LOAD_RD;
			S_IDXADD:  state_d = S_DONE;
			S_ROW:     state_d = S_DONE;
			S_DONE:    if (out_free) state_d = S_IDLE;
			default:   state_d = S_IDLE;
		endcase
	end

	// datapath controls
	always_comb begin
		mem_req.we    = 1'b0;
		mem_req.addr  = ADDR_W'(pc_q);
		mem_req.wdata = 8'd0;
		pix_ra        = '0;
		pix_we        = 1'b0;
		pix_wa        = '0;
		pix_wd        = '0;
		ra            = rx;
		rf_we         = 1'b0;
		rf_wa         = rx;
		rf_wd         = 8'd0;
		alu_op        = ALU_XOR;
		alu_a         = vx_q;
		alu_b         = nn;
		case (state_q)
			S_CLEAR: begin
				mem_req.we   = 1'b1;
				mem_req.addr = clr_q;
				pix_we       = (clr_q < ADDR_W'(SCREEN_H));
				pix_wa       = clr_q[ROW_W-1:0];
			end
			S_IDLE: begin
				if (accept && item.mode == MODE_LOAD) begin
					mem_req.we    = 1'b1;
					mem_req.addr  = ADDR_W'(item.load_address);
					mem_req.wdata = item.load_byte;
				end
				pix_ra = item.row_select;
			end
			S_FETCH1: mem_req.addr = ADDR_W'(pc_q + PC_W'(1));
			S_RDY: begin
				if (opg == G_JPV)
					ra = cfg.super_quirks ? rx : 4'd0;
				else
					ra = ry;
			end
			S_EXEC: begin
				case (opg)
					G_SER, G_SNER: alu_b = vy_q;
					G_LD: begin
						rf_we = 1'b1;
						rf_wd = nn;
					end
					G_ADD: begin
						alu_op = ALU_ADD;
						rf_we  = 1'b1;
						rf_wd  = alu_y.res;
					end
					G_ALU: begin
						alu_b = vy_q;
						rf_we = 1'b1;
						rf_wd = alu_y.res;
						case (rn)
							N_MOV:  alu_op = ALU_PASS_B;
							N_OR:   alu_op = ALU_OR;
							N_AND:  alu_op = ALU_AND;
							N_XOR:  alu_op = ALU_XOR;
							N_ADD:  alu_op = ALU_ADD;
							N_SUB:  alu_op = ALU_SUB;
							N_SUBN: alu_op = ALU_SUBN;
							N_SHR: begin
								alu_op = ALU_SHR;
								alu_a  = cfg.super_quirks ? vx_q : vy_q;
							end
							N_SHL: begin
								alu_op = ALU_SHL;
								alu_a  = cfg.super_quirks ? vx_q : vy_q;
							end
							default: rf_we = 1'b0;
						endcase
					end
					G_RND: begin
						rf_we = 1'b1;
						rf_wd = item_q.random_byte & nn;
					end
					G_MISC: begin
						case (nn)
							FX_GET_DELAY: begin
								rf_we = 1'b1;
								rf_wd = dt_q;
							end
							FX_WAIT_KEY: begin
								rf_we = key_any;
								rf_wd = {4'b0, key_low};
							end
							default: rf_we = 1'b0;
						endcase
					end
					default: rf_we = 1'b0;
				endcase
			end
			S_WRF: begin
				rf_we = 1'b1;
				rf_wa = 4'hF;
				rf_wd = {7'b0, flag_q};
			end
			S_CLS: begin
				pix_ra = cnt_q[ROW_W-1:0];
				pix_we = (cnt_q != '0);
				pix_wa = cnt_m1[ROW_W-1:0];
			end
			S_DRAW_RD: begin
				mem_req.addr = idx_mem;
				pix_ra       = draw_row[ROW_W-1:0];
			end
			S_DRAW_WR: begin
				pix_we = 1'b1;
				pix_wa = draw_row[ROW_W-1:0];
				pix_wd = pix_rd_q ^ sprite;
			end
			S_DRAW_VF: begin
				rf_we = 1'b1;
				rf_wa = 4'hF;
				rf_wd = {7'b0, coll_q};
			end
			S_BCD: begin
				mem_req.we    = 1'b1;
				mem_req.addr  = idx_mem;
				mem_req.wdata = bcd_digit(vx_q, cnt_q[1:0]);
			end
			S_STORE: begin
				ra            = cnt_q[3:0];
				mem_req.we    = 1'b1;
				mem_req.addr  = idx_mem;
				mem_req.wdata = rf_rd;
			end
			S_LOAD_RD: mem_req.addr = idx_mem;
			S_LOAD_WR: begin
				rf_we = 1'b1;
				rf_wa = cnt_q[3:0];
				rf_wd = mem_rdata;
			end
			default: rf_we = 1'b0;
		endcase
	end

	// display memory
	always_ff @(posedge clk) begin
		if (pix_we) begin
			pix_q[pix_wa] <= pix_wd;
		end
		pix_rd_q <= pix_q[pix_ra];
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= item;
		end
		case (state_q)
			S_FETCH1: op_q[15:8] <= mem_rdata;
			S_FETCH2: op_q[7:0]  <= mem_rdata;
			S_RDX:    vx_q       <= rf_rd;
			S_RDY:    vy_q       <= rf_rd;
			default:  vx_q       <= vx_q;
		endcase
	end

	// control and architectural registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLEAR;
			clr_q     <= '0;
			cnt_q     <= '0;
			sp_q      <= '0;
			pc_q      <= RESET_PC;
			idx_q     <= '0;
			dt_q      <= '0;
			st_q      <= '0;
			flag_q    <= 1'b0;
			coll_q    <= 1'b0;
			changed_q <= 1'b0;
			waiting_q <= 1'b0;
			row_q     <= '0;
			for (int i = 0; i < 16; i++) rf_q[i] <= '0;
			for (int i = 0; i < STACK_DEPTH; i++) stack_q[i] <= '0;
		end else begin
			state_q <= state_d;
			if (rf_we) begin
				rf_q[rf_wa] <= rf_wd;
			end
			case (state_q)
				S_CLEAR: clr_q <= clr_q + ADDR_W'(1);
				S_IDLE: begin
					if (accept) begin
						changed_q <= 1'b0;
						waiting_q <= 1'b0;
						row_q     <= '0;
						if (item.mode == MODE_TICK) begin
							if (dt_q != 8'd0) dt_q <= dt_q - 8'd1;
							if (st_q != 8'd0) st_q <= st_q - 8'd1;
						end
					end
				end
				S_FETCH2: pc_q <= pc_q + PC_W'(2);
				S_EXEC: begin
					cnt_q  <= '0;
					coll_q <= 1'b0;
					case (opg)
						G_SYS: begin
							if (op_q == OP_RET) begin
								sp_q <= sp_dec;
								pc_q <= stack_q[sp_dec];
							end
						end
						G_JP: pc_q <= nnn;
						G_CALL: begin
							stack_q[sp_q] <= pc_q;
							sp_q          <= sp_inc;
							pc_q          <= nnn;
						end
						G_SE:   if (alu_zero) pc_q <= pc_q + PC_W'(2);
						G_SNE:  if (!alu_zero) pc_q <= pc_q + PC_W'(2);
						G_SER:  if (rn == 4'd0 && alu_zero) pc_q <= pc_q + PC_W'(2);
						G_SNER: if (!alu_zero) pc_q <= pc_q + PC_W'(2);
						G_ALU:  flag_q <= alu_y.flag;
						G_LDI:  idx_q <= 16'(nnn);
						G_JPV:  pc_q <= nnn + {4'b0, vy_q};
						G_KEY: begin
							if ((nn == EX_SKP && key_held) || (nn == EX_SKNP && !key_held))
								pc_q <= pc_q + PC_W'(2);
						end
						G_MISC: begin
							case (nn)
								FX_SET_DELAY: dt_q <= vx_q;
								FX_SET_SOUND: st_q <= vx_q;
								FX_ADD_INDEX: begin
									idx_q  <= idx_sum;
									flag_q <= (idx_sum > ADDR_MASK);
								end
								FX_WAIT_KEY: begin
									if (!key_any) begin
										pc_q      <= pc_q - PC_W'(2);
										waiting_q <= 1'b1;
									end
								end
								FX_FONT: idx_q <= 16'({vx_q[3:0], 2'b00}) + 16'(vx_q[3:0]) + FONT_BASE;
								default: flag_q <= flag_q;
							endcase
						end
						default: flag_q <= flag_q;
					endcase
				end
				S_CLS: begin
					if (cnt_q != '0 && pix_rd_q != '0) changed_q <= 1'b1;
					cnt_q <= cnt_q + CNT_W'(1);
				end
				S_DRAW_WR: begin
					if ((pix_rd_q & sprite) != '0) coll_q <= 1'b1;
					if (sprite != '0) changed_q <= 1'b1;
					cnt_q <= cnt_q + CNT_W'(1);
				end
				S_BCD, S_STORE, S_LOAD_WR: cnt_q <= cnt_q + CNT_W'(1);
				S_IDXADD: if (!cfg.super_quirks) idx_q <= idx_q + 16'(rx) + 16'd1;
				S_ROW: row_q <= pix_rd_q;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

[src/chip8_instruction_core.sv]
// CHIP-8 processor core, one transaction per instruction, timer tick, memory byte
// load or display row read. After reset the core sweeps its 4096-byte memory and
// the 32 display rows to zero, one address a cycle; input is stalled until the
// sweep ends, config writes are taken throughout. Items run one at a time through
// a small sequencer around a single 8-bit ALU, one register-file read port and one
// port on the main memory. An ordinary instruction passes through fetch of both
// opcode bytes, 2 register reads, execute and finish; 00E0 clears one display row
// per cycle; DXYN reads and writes back each drawn row in turn, then sets VF; FX55
// stores and FX65 reads then writes each register V0..VX in turn; FX33 writes the
// hundreds, tens and units digits. Config registers
// (super_quirks, index_overflow_flag) are written through cfg_valid/cfg_ready,
// always ready, and must only change while the core is idle.
module chip8_instruction_core (
	input  logic              clk,
	input  logic              arst_n,
	// item transaction
	input  logic              item_valid,
	output logic              item_stall,
	input  c8ic_pkg::item_t   item,
	// result transaction
	output logic              result_valid,
	input  logic              result_stall,
	output c8ic_pkg::result_t result,
	// config write
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic              cfg_index,
	input  logic              cfg_data
);
	import c8ic_pkg::*;

	cfg_t     cfg_q;
	logic     out_valid_q;
	result_t  out_q;
	logic     out_free;
	logic     done;
	result_t  res;
	mem_req_t mem_req;
	logic [7:0] mem_rdata;

	assign cfg_ready = 1'b1;

	// quirk registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_SUPER_QUIRKS:   cfg_q.super_quirks        <= cfg_data;
				CFG_INDEX_OVERFLOW: cfg_q.index_overflow_flag <= cfg_data;
				default:            cfg_q <= cfg_q;
			endcase
		end
	end

	// output register: a finished result may wait here while the sequencer
	// moves on to the next transaction
	assign out_free = !out_valid_q || !result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (done) begin
			out_valid_q <= 1'b1;
		end else if (!result_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			out_q <= res;
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

	c8ic_ram u_ram (
		.clk   (clk),
		.req   (mem_req),
		.rdata (mem_rdata)
	);

	c8ic_seq u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item       (item),
		.item_stall (item_stall),
		.cfg        (cfg_q),
		.out_free   (out_free),
		.done       (done),
		.res        (res),
		.mem_req    (mem_req),
		.mem_rdata  (mem_rdata)
	);

	// an accepted transaction holds the input off for at least the next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall |=> item_stall)
		else $error("input taken on consecutive cycles");

	// a key wait never comes with a display change
	a_wait_no_draw: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !(result.screen_changed && result.waiting_for_key))
		else $error("waiting_for_key with screen_changed");

	// a fresh result only ever follows work in flight
	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(item_stall))
		else $error("result without an item in progress");

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 100ps

module testbench;
	import c8ic_pkg::*;

	localparam int STALL_LIMIT = 20000;  // covers the clearing sweep after reset
	localparam int HOLD_CYCLES = 400;
	localparam int SETTLE      = 60;     // margin for the sequencer after the last result
	localparam int STEPS       = 56;     // random steps per phase, ~2.4 items each

	// Shadow of the core: full architectural state plus the expected results
	class chip8_shadow;
		logic [7:0]  mem [4096];
		logic [7:0]  v [16];
		logic [11:0] stk [16];
		logic [3:0]  sp;
		logic [11:0] pc;
		logic [15:0] idx;
		logic [7:0]  dly, snd;
		logic [63:0] scr [32];
		bit          quirk, ovf_flag;
		result_t     pending_results [$];
		int          mismatches;

		function new();
			foreach (mem[i]) mem[i] = '0;
			foreach (v[i]) v[i] = '0;
			foreach (stk[i]) stk[i] = '0;
			foreach (scr[i]) scr[i] = '0;
			sp = '0;
			pc = RESET_PC;
			idx = '0;
			dly = '0;
			snd = '0;
			quirk = 0;
			ovf_flag = 0;
			mismatches = 0;
		endfunction

		function void set_reg(logic sel, logic val);
			if (sel == CFG_SUPER_QUIRKS) quirk = val;
			else ovf_flag = val;
		endfunction

		// Work out the result of one accepted transaction and queue it
		function void note_item(item_t it);
			result_t     r;
			logic [15:0] op;
			logic [3:0]  x, y, n;
			logic [7:0]  nn, vx, vy, bits;
			logic [11:0] nnn;
			logic [8:0]  sum;
			logic [63:0] m;
			logic [5:0]  x0;
			logic [4:0]  y0;
			bit          f, held, found;
			int          i, c;
			r = '0;
			case (it.mode)
				MODE_EXEC: begin
					op = {mem[pc], mem[pc + 12'd1]};
					x = op[11:8];
					y = op[7:4];
					n = op[3:0];
					nn = op[7:0];
					nnn = op[11:0];
					pc = pc + 12'd2;
					vx = v[x];
					vy = v[y];
					case (op[15:12])
						G_SYS: begin
							if (op == OP_CLS) begin
								for (i = 0; i < 32; i++) begin
									if (scr[i] != 0) r.screen_changed = 1;
									scr[i] = '0;
								end
							end else if (op == OP_RET) begin
								sp = sp - 4'd1;
								pc = stk[sp];
							end
						end
						G_JP: pc = nnn;
						G_CALL: begin
							stk[sp] = pc;
							sp = sp + 4'd1;
							pc = nnn;
						end
						G_SE: if (vx == nn) pc = pc + 12'd2;
						G_SNE: if (vx != nn) pc = pc + 12'd2;
						G_SER: if (n == 0 && vx == vy) pc = pc + 12'd2;
						G_LD: v[x] = nn;
						G_ADD: v[x] = vx + nn;
						G_ALU: begin
							case (n)
								N_MOV: v[x] = vy;
								N_OR:  v[x] = vx | vy;
								N_AND: v[x] = vx & vy;
								N_XOR: v[x] = vx ^ vy;
								N_ADD: begin
									sum = {1'b0, vx} + {1'b0, vy};
									v[x] = sum[7:0];
									v[15] = {7'd0, sum[8]};
								end
								N_SUB: begin
									f = vx >= vy;
									v[x] = vx - vy;
									v[15] = {7'd0, f};
								end
								N_SUBN: begin
									f = vy >= vx;
									v[x] = vy - vx;
									v[15] = {7'd0, f};
								end
								N_SHR: begin
									if (!quirk) vx = vy;
									v[x] = vx >> 1;
									v[15] = {7'd0, vx[0]};
								end
								N_SHL: begin
									if (!quirk) vx = vy;
									v[x] = vx << 1;
									v[15] = {7'd0, vx[7]};
								end
								default: ;
							endcase
						end
						G_SNER: if (vx != vy) pc = pc + 12'd2;
						G_LDI: idx = {4'h0, nnn};
						G_JPV: pc = nnn + {4'h0, (quirk ? vx : v[0])};
						G_RND: v[x] = it.random_byte & nn;
						G_DRW: begin
							// clipped at right and bottom edges, VF flags any collision
							v[15] = '0;
							x0 = vx[5:0];
							y0 = vy[4:0];
							for (i = 0; i < n && y0 + i < 32; i++) begin
								bits = mem[idx[11:0] + 12'(i)];
								for (c = 0; c < 8 && x0 + c < 64; c++) begin
									if (bits[7 - c]) begin
										m = 64'h1 << (63 - (x0 + c));
										if ((scr[y0 + i] & m) != 0) v[15] = 8'd1;
										scr[y0 + i] = scr[y0 + i] ^ m;
										r.screen_changed = 1;
									end
								end
							end
						end
						G_KEY: begin
							held = (vx < 16) && it.key_mask[vx[3:0]];
							if (nn == EX_SKP && held) pc = pc + 12'd2;
							else if (nn == EX_SKNP && !held) pc = pc + 12'd2;
						end
						G_MISC: begin
							case (nn)
								FX_GET_DELAY: v[x] = dly;
								FX_SET_DELAY: dly = vx;
								FX_SET_SOUND: snd = vx;
								FX_ADD_INDEX: begin
									idx = idx + {8'd0, vx};
									if (ovf_flag) v[15] = (idx > ADDR_MASK) ? 8'd1 : 8'd0;
								end
								FX_WAIT_KEY: begin
									found = 0;
									for (i = 0; i < 16; i++) begin
										if (!found && it.key_mask[i]) begin
											found = 1;
											v[x] = 8'(i);
										end
									end
									if (!found) begin
										pc = pc - 12'd2;
										r.waiting_for_key = 1;
									end
								end
								FX_FONT: idx = FONT_BASE + 16'(vx[3:0]) * 16'd5;
								FX_BCD: begin
									mem[idx[11:0]] = vx / 8'd100;
									mem[idx[11:0] + 12'd1] = (vx / 8'd10) % 8'd10;
									mem[idx[11:0] + 12'd2] = vx % 8'd10;
								end
								FX_STORE: begin
									for (i = 0; i <= x; i++) mem[idx[11:0] + 12'(i)] = v[i];
									if (!quirk) idx = idx + 16'(x) + 16'd1;
								end
								FX_LOAD: begin
									for (i = 0; i <= x; i++) v[i] = mem[idx[11:0] + 12'(i)];
									if (!quirk) idx = idx + 16'(x) + 16'd1;
								end
								default: ;
							endcase
						end
						default: ;
					endcase
				end
				MODE_TICK: begin
					if (dly != 0) dly = dly - 8'd1;
					if (snd != 0) snd = snd - 8'd1;
				end
				MODE_LOAD: mem[it.load_address] = it.load_byte;
				default: r.row_pixels = scr[it.row_select];
			endcase
			r.program_counter = pc;
			r.sound_active = (snd != 0);
			pending_results.push_back(r);
		endfunction

		function void note_error();
			mismatches++;
		endfunction

		function void check_result(result_t got);
			result_t exp;
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result: %p", got);
			end else begin
				exp = pending_results.pop_front();
				if (got !== exp) begin
					mismatches++;
					if (mismatches <= 10)
						$display("result mismatch: pc %h/%h chg %b/%b snd %b/%b wait %b/%b row %h/%h",
							exp.program_counter, got.program_counter,
							exp.screen_changed, got.screen_changed,
							exp.sound_active, got.sound_active,
							exp.waiting_for_key, got.waiting_for_key,
							exp.row_pixels, got.row_pixels);
				end
			end
		endfunction
	endclass

	logic    clk;
	logic    arst_n;
	logic    item_valid, item_stall;
	item_t   item;
	logic    result_valid, result_stall;
	result_t result;
	logic    cfg_valid, cfg_ready, cfg_index, cfg_data;

	chip8_shadow shadow = new();
	int  n_items, n_results, n_cfg, quiet_cycles;
	bit  idling, hold_req;

	chip8_instruction_core u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	// Sample every channel at the rising edge. Results are checked before the
	// incoming transaction is noted, since a result always belongs to an older item.
	always @(posedge clk) begin
		bit moved;
		moved = 0;
		if (result_valid && !result_stall) begin
			shadow.check_result(result);
			n_results++;
			moved = 1;
		end
		if (item_valid && !item_stall) begin
			shadow.note_item(item);
			n_items++;
			moved = 1;
		end
		if (cfg_valid && cfg_ready) begin
			shadow.set_reg(cfg_index, cfg_data);
			n_cfg++;
			moved = 1;
		end
		quiet_cycles = moved ? 0 : quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// Result side: random stall bursts, plus one long hold-off on request
	initial begin
		bit hold_done;
		hold_done = 0;
		result_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req && !hold_done) begin
				result_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_done = 1;
				result_stall <= 1'b0;
			end else if (idling && $urandom_range(0, 7) == 0) begin
				result_stall <= 1'b1;
				repeat ($urandom_range(1, 11)) @(negedge clk);
				result_stall <= 1'b0;
			end else begin
				result_stall <= 1'b0;
			end
		end
	end

	// Offer one transaction and hold it until taken; valid stays high into
	// the next item unless a gap is drawn.
	task automatic send_item(input item_t it);
		int target;
		item <= it;
		item_valid <= 1'b1;
		target = n_items + 1;
		do @(negedge clk); while (n_items < target);
		if (idling && $urandom_range(0, 5) == 0) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(negedge clk);
		end
	endtask

	function automatic item_t random_item(input mode_t md);
		logic [63:0] bits;
		item_t it;
		bits = {$urandom, $urandom};
		it = bits[$bits(item_t)-1:0];
		if ($urandom_range(0, 3) == 0) it.key_mask = '0;
		it.mode = md;
		return it;
	endfunction

	task automatic load_at(input logic [11:0] a, input logic [7:0] b);
		item_t it;
		it = random_item(MODE_LOAD);
		it.load_address = a;
		it.load_byte = b;
		send_item(it);
	endtask

	// Plant an instruction at the current counter, then execute it
	task automatic run_op(input logic [15:0] op, input logic [15:0] keys);
		item_t it;
		load_at(shadow.pc, op[15:8]);
		load_at(shadow.pc + 12'd1, op[7:0]);
		it = random_item(MODE_EXEC);
		it.key_mask = keys;
		send_item(it);
	endtask

	function automatic logic [15:0] random_op();
		logic [15:0] op;
		logic [3:0]  alu_codes [11];
		logic [7:0]  misc_codes [12];
		alu_codes = '{N_MOV, N_OR, N_AND, N_XOR, N_ADD, N_SUB, N_SHR, N_SUBN, N_SHL,
			4'h8, 4'hF};
		misc_codes = '{FX_GET_DELAY, FX_WAIT_KEY, FX_SET_DELAY, FX_SET_SOUND, FX_ADD_INDEX,
			FX_FONT, FX_BCD, FX_STORE, FX_LOAD, FX_ADD_INDEX, FX_SET_SOUND, 8'h00};
		op = 16'($urandom);
		case (op[15:12])
			G_SYS: begin
				case ($urandom_range(0, 2))
					0: op = OP_CLS;
					1: op = OP_RET;
					default: ;
				endcase
			end
			G_SER: if ($urandom_range(0, 3) != 0) op[3:0] = '0;
			G_ALU: op[3:0] = alu_codes[$urandom_range(0, 10)];
			G_KEY: begin
				case ($urandom_range(0, 4))
					0, 1: op[7:0] = EX_SKP;
					2, 3: op[7:0] = EX_SKNP;
					default: ;
				endcase
			end
			G_MISC: begin
				misc_codes[11] = 8'($urandom);
				op[7:0] = misc_codes[$urandom_range(0, 11)];
			end
			default: ;
		endcase
		return op;
	endfunction

	task automatic random_step();
		int pick;
		pick = $urandom_range(0, 19);
		if (pick < 14) run_op(random_op(), 16'($urandom) & {16{$urandom_range(0, 3) != 0}});
		else if (pick < 16) send_item(random_item(MODE_TICK));
		else if (pick < 18) send_item(random_item(MODE_ROW));
		else if (pick == 18) send_item(random_item(MODE_LOAD));
		else send_item(random_item(MODE_EXEC));  // whatever lies at the counter
	endtask

	// Let everything outstanding come back, then a margin for the sequencer
	task automatic drain();
		item_valid <= 1'b0;
		do @(negedge clk); while (shadow.pending_results.size() != 0);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic write_config(input logic q, input logic o);
		int target;
		cfg_index <= CFG_SUPER_QUIRKS;
		cfg_data <= q;
		cfg_valid <= 1'b1;
		target = n_cfg + 1;
		do @(negedge clk); while (n_cfg < target);
		cfg_index <= CFG_INDEX_OVERFLOW;
		cfg_data <= o;
		target = n_cfg + 1;
		do @(negedge clk); while (n_cfg < target);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	initial begin
		logic [1:0] settings [6];
		item_t it;
		settings = '{2'b11, 2'b10, 2'b01, 2'b00, 2'b11, 2'b01};
		arst_n = 1'b0;
		item_valid = 1'b0;
		item = '0;
		cfg_valid = 1'b0;
		cfg_index = CFG_SUPER_QUIRKS;
		cfg_data = 1'b0;
		idling = 1;
		hold_req = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		write_config(1'b0, 1'b0);

		// directed: carry, flag order with X = F, key wait, draw, stack underflow
		run_op(16'h60FF, 16'h0000);
		run_op(16'h8004, 16'hFFFF);
		run_op(16'h8FFE, 16'h0000);
		run_op(16'hF00A, 16'h0000);
		run_op(16'hF00A, 16'h8001);
		run_op(16'hD01F, 16'h0000);
		run_op(16'h00EE, 16'h0000);
		send_item(random_item(MODE_TICK));
		it = random_item(MODE_ROW);
		it.row_select = 5'd31;
		send_item(it);
		load_at(12'hFFF, 8'hFF);

		for (int ph = 0; ph < 6; ph++) begin
			drain();
			write_config(settings[ph][1], settings[ph][0]);
			if (ph == 5) idling = 0;
			if (ph == 1) hold_req = 1;  // block fills up while results are held off
			for (int s = 0; s < STEPS; s++) begin
				if (ph == 2 && s == STEPS / 2) begin
					item_valid <= 1'b0;
					do @(negedge clk); while (shadow.pending_results.size() != 0);
				end
				random_step();
			end
		end

		drain();
		if (shadow.pending_results.size() != 0) shadow.note_error();
		if (shadow.mismatches == 0) $display("status: pass");
		else $display("status: fail");
		$finish;
	end

endmodule
